[rtl/tdma_pkg.sv]
package tdma_pkg;

  // Default values for the top level parameters.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TAG_BITS_DEF    = 16;
  localparam int ADDR_BITS_DEF   = 8;

  // Fixed field widths.
  localparam int TICK_BITS     = 24;
  localparam int LIMIT_BITS    = 5;
  localparam int PER_SLOT_BITS = 8;
  localparam int POLICY_BITS   = 2;
  localparam int MY_ADDR_BITS  = 8;
  localparam int MODE_BITS     = 3;
  localparam int VERDICT_BITS  = 3;
  localparam int RADIO_BITS    = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SLOT        = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GUARD       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_DELAY = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_QUEUE_LIMIT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PER_SLOT = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DROP_POLICY = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MY_ADDR     = 3'd7;

  // Configuration reset values.
  localparam logic [TICK_BITS-1:0]     FRAME_RESET    = 24'd1000;
  localparam logic [LIMIT_BITS-1:0]    LIMIT_RESET    = 5'd10;
  localparam logic [PER_SLOT_BITS-1:0] PER_SLOT_RESET = 8'd1;

  // Full-queue policies.
  localparam logic [POLICY_BITS-1:0] POLICY_DROP_NEW = 2'd0;
  localparam logic [POLICY_BITS-1:0] POLICY_DROP_OLD = 2'd1;
  localparam logic [POLICY_BITS-1:0] POLICY_PRIORITY = 2'd2;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_TICK     = 3'd0,
    MODE_ENQ      = 3'd1,
    MODE_TX_END   = 3'd2,
    MODE_RX_START = 3'd3,
    MODE_RX_END   = 3'd4,
    MODE_START    = 3'd5,
    MODE_STOP     = 3'd6,
    MODE_NOP      = 3'd7
  } mode_t;

  typedef enum logic [VERDICT_BITS-1:0] {
    VERD_NONE     = 3'd0,
    VERD_DELIVER  = 3'd1,
    VERD_CORRUPT  = 3'd2,
    VERD_NOT_MINE = 3'd3,
    VERD_TX_BUSY  = 3'd4
  } verdict_t;

  typedef enum logic [RADIO_BITS-1:0] {
    RADIO_IDLE = 2'd0,
    RADIO_TX   = 2'd1,
    RADIO_RX   = 2'd2
  } radio_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_POP  = 2'd2,
    S_FIN  = 2'd3
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic pop;
    logic load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

[rtl/tdma_if.sv]
interface tdma_in_if #(
  parameter int TAG_BITS  = 16,
  parameter int ADDR_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           mode;
  logic [TAG_BITS-1:0]  packet_tag;
  logic                 high_priority;
  logic [ADDR_BITS-1:0] dest_addr;
  logic                 rx_error;

  modport source (output valid, mode, packet_tag, high_priority, dest_addr, rx_error,
                  input ready);
  modport sink (input valid, mode, packet_tag, high_priority, dest_addr, rx_error,
                output ready);
endinterface

interface tdma_out_if #(
  parameter int TAG_BITS = 16,
  parameter int CNT_BITS = 5
);
  logic                valid;
  logic                ready;
  logic                tx_start;
  logic [TAG_BITS-1:0] tx_tag;
  logic [2:0]          rx_verdict;
  logic                dropped;
  logic [TAG_BITS-1:0] dropped_tag;
  logic                slot_mine;
  logic [CNT_BITS-1:0] queue_count;
  logic [1:0]          radio_state;

  modport source (output valid, tx_start, tx_tag, rx_verdict, dropped, dropped_tag,
                  slot_mine, queue_count, radio_state, input ready);
  modport sink (input valid, tx_start, tx_tag, rx_verdict, dropped, dropped_tag,
                slot_mine, queue_count, radio_state, output ready);
endinterface

interface tdma_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/tdma_ram.sv]
module tdma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/tdma_ctrl.sv]
module tdma_ctrl
  import tdma_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC:  state_next = S_POP;
      S_POP:   state_next = S_FIN;
      S_FIN: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // No item is taken while reset is held.
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state)
      S_IDLE: begin
        in_ready  = !rst;
        cmd.latch = in_valid && !rst;
      end
      S_EXEC:  cmd.exec = 1'b1;
      S_POP:   cmd.pop  = 1'b1;
      S_FIN:   cmd.load = status.out_free;
      default: cmd      = '0;
    endcase
  end

endmodule

[rtl/tdma_dp.sv]
module tdma_dp
  import tdma_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF,
  parameter int CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  // item payload
  input  logic [MODE_BITS-1:0]     in_mode,
  input  logic [TAG_BITS-1:0]      in_tag,
  input  logic                     in_hi,
  input  logic [ADDR_BITS-1:0]     in_dest,
  input  logic                     in_err,
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // result register
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_tx_start,
  output logic [TAG_BITS-1:0]      out_tx_tag,
  output logic [VERDICT_BITS-1:0]  out_rx_verdict,
  output logic                     out_dropped,
  output logic [TAG_BITS-1:0]      out_dropped_tag,
  output logic                     out_slot_mine,
  output logic [CNT_BITS-1:0]      out_queue_count,
  output logic [RADIO_BITS-1:0]    out_radio_state
);

  localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int SUM_BITS = IDX_BITS + 2;
  localparam int LIM_BITS = (CNT_BITS > LIMIT_BITS) ? CNT_BITS : LIMIT_BITS;

  // Configuration registers.
  logic [TICK_BITS-1:0]     frame_ticks, slot_ticks, guard_ticks, start_delay_ticks;
  logic [LIMIT_BITS-1:0]    queue_limit;
  logic [PER_SLOT_BITS-1:0] max_per_slot;
  logic [POLICY_BITS-1:0]   drop_policy;
  logic [MY_ADDR_BITS-1:0]  my_addr;

  // Scheduler state.
  logic                     own_slot;
  logic [TICK_BITS-1:0]     slot_countdown;
  logic                     timer_running;
  logic [PER_SLOT_BITS-1:0] sent_this_slot;
  radio_t                   radio;
  logic [IDX_BITS-1:0]      head;
  logic [CNT_BITS-1:0]      fill;

  // Latched item and per-item flags.
  mode_t                    mode_r;
  logic [TAG_BITS-1:0]      tag_r;
  logic                     hi_r;
  logic [ADDR_BITS-1:0]     dest_r;
  logic                     err_r;
  logic                     attempt;
  logic                     tx_flag;
  logic                     drop_flag;
  logic                     drop_ram;
  verdict_t                 verdict;
  logic [TAG_BITS-1:0]      drop_tag_q;

  // Queue addressing.
  logic [IDX_BITS-1:0]      head_inc, head_dec, back_idx, last_idx;
  logic [SUM_BITS-1:0]      back_sum, last_sum;
  logic [LIM_BITS-1:0]      limit;
  logic                     room;
  logic                     enq_front, enq_back, evict_front, evict_back, drop_new;

  // Slot arithmetic.
  logic [TICK_BITS:0]       off_sum, off_diff;
  logic [TICK_BITS-1:0]     off_ticks, on_ticks;
  logic                     tx_go;
  logic                     addr_match;

  // Tag store.
  logic                     ram_we;
  logic [IDX_BITS-1:0]      ram_waddr, ram_raddr;
  logic [TAG_BITS-1:0]      ram_rdata;

  assign cfg_ready       = !rst;
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    head_inc = (head == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
    head_dec = (head == '0) ? IDX_BITS'(QUEUE_DEPTH - 1) : head - 1'b1;
    back_sum = SUM_BITS'(head) + SUM_BITS'(fill);
    last_sum = back_sum - 1'b1;
    back_idx = (back_sum >= SUM_BITS'(QUEUE_DEPTH)) ?
               IDX_BITS'(back_sum - SUM_BITS'(QUEUE_DEPTH)) : IDX_BITS'(back_sum);
    last_idx = (last_sum >= SUM_BITS'(QUEUE_DEPTH)) ?
               IDX_BITS'(last_sum - SUM_BITS'(QUEUE_DEPTH)) : IDX_BITS'(last_sum);
  end

  // Effective capacity is the smaller of the register and the physical depth.
  always_comb begin
    limit = (LIM_BITS'(queue_limit) > LIM_BITS'(QUEUE_DEPTH)) ?
            LIM_BITS'(QUEUE_DEPTH) : LIM_BITS'(queue_limit);
    room  = LIM_BITS'(fill) < limit;
  end

  always_comb begin
    enq_front   = 1'b0;
    enq_back    = 1'b0;
    evict_front = 1'b0;
    evict_back  = 1'b0;
    drop_new    = 1'b0;
    if (room) begin
      if (drop_policy == POLICY_PRIORITY && hi_r) begin
        enq_front = 1'b1;
      end else begin
        enq_back = 1'b1;
      end
    end else if (drop_policy == POLICY_DROP_OLD && fill != '0) begin
      evict_front = 1'b1;
    end else if (drop_policy == POLICY_PRIORITY && hi_r && fill != '0) begin
      evict_back = 1'b1;
    end else begin
      drop_new = 1'b1;
    end
  end

  always_comb begin
    off_sum   = {1'b0, frame_ticks} + {1'b0, guard_ticks};
    off_diff  = off_sum - {1'b0, slot_ticks};
    off_ticks = (off_sum > {1'b0, slot_ticks}) ?
                (off_diff[TICK_BITS] ? '1 : off_diff[TICK_BITS-1:0]) : '0;
    on_ticks  = (slot_ticks > guard_ticks) ? slot_ticks - guard_ticks : '0;
  end

  assign addr_match = (dest_r == ADDR_BITS'(my_addr)) || (&dest_r);

  assign tx_go = attempt && (sent_this_slot < max_per_slot) && own_slot &&
                 (radio == RADIO_IDLE) && (fill != '0);

  // Writes happen only while executing an enqueue; the read port serves the
  // evicted entry during execution and the queue front in the pop cycle.
  // Once a packet has left, the read stays on that entry so that its tag is
  // still on the read port however long the result register is busy.
  always_comb begin
    ram_we    = cmd.exec && (mode_r == MODE_ENQ) && !drop_new;
    ram_waddr = (enq_front || evict_back) ? head_dec : back_idx;
    ram_raddr = (cmd.exec && evict_back) ? last_idx : (tx_flag ? head_dec : head);
  end

  tdma_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_tag_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tag_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ticks       <= FRAME_RESET;
      slot_ticks        <= '0;
      guard_ticks       <= '0;
      start_delay_ticks <= '0;
      queue_limit       <= LIMIT_RESET;
      max_per_slot      <= PER_SLOT_RESET;
      drop_policy       <= POLICY_DROP_NEW;
      my_addr           <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME:        frame_ticks       <= cfg_data[TICK_BITS-1:0];
        CFG_SLOT:         slot_ticks        <= cfg_data[TICK_BITS-1:0];
        CFG_GUARD:        guard_ticks       <= cfg_data[TICK_BITS-1:0];
        CFG_START_DELAY:  start_delay_ticks <= cfg_data[TICK_BITS-1:0];
        CFG_QUEUE_LIMIT:  queue_limit       <= cfg_data[LIMIT_BITS-1:0];
        CFG_MAX_PER_SLOT: max_per_slot      <= cfg_data[PER_SLOT_BITS-1:0];
        CFG_DROP_POLICY:  drop_policy       <= cfg_data[POLICY_BITS-1:0];
        CFG_MY_ADDR:      my_addr           <= cfg_data[MY_ADDR_BITS-1:0];
        default:          my_addr           <= my_addr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= mode_t'(in_mode);
      tag_r  <= in_tag;
      hi_r   <= in_hi;
      dest_r <= in_dest;
      err_r  <= in_err;
    end
    if (cmd.exec && mode_r == MODE_ENQ && drop_new) begin
      drop_tag_q <= tag_r;
    end
    if (cmd.pop && drop_ram) begin
      drop_tag_q <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_slot       <= 1'b0;
      slot_countdown <= '0;
      timer_running  <= 1'b0;
      sent_this_slot <= '0;
      radio          <= RADIO_IDLE;
      head           <= '0;
      fill           <= '0;
      attempt        <= 1'b0;
      tx_flag        <= 1'b0;
      drop_flag      <= 1'b0;
      drop_ram       <= 1'b0;
      verdict        <= VERD_NONE;
    end else begin
      if (cmd.latch) begin
        attempt   <= 1'b0;
        tx_flag   <= 1'b0;
        drop_flag <= 1'b0;
        drop_ram  <= 1'b0;
        verdict   <= VERD_NONE;
      end
      if (cmd.exec) begin
        case (mode_r)
          MODE_TICK: begin
            if (timer_running) begin
              if (slot_countdown <= TICK_BITS'(1)) begin
                sent_this_slot <= '0;
                own_slot       <= !own_slot;
                if (own_slot) begin
                  slot_countdown <= off_ticks;
                end else begin
                  slot_countdown <= on_ticks;
                  attempt        <= 1'b1;
                end
              end else begin
                slot_countdown <= slot_countdown - 1'b1;
              end
            end
          end
          MODE_ENQ: begin
            attempt <= 1'b1;
            if (enq_front) begin
              head <= head_dec;
              fill <= fill + 1'b1;
            end else if (enq_back) begin
              fill <= fill + 1'b1;
            end else if (evict_front) begin
              head      <= head_inc;
              drop_flag <= 1'b1;
              drop_ram  <= 1'b1;
            end else if (evict_back) begin
              head      <= head_dec;
              drop_flag <= 1'b1;
              drop_ram  <= 1'b1;
            end else begin
              drop_flag <= 1'b1;
            end
          end
          MODE_TX_END: begin
            radio   <= RADIO_IDLE;
            attempt <= 1'b1;
            if (sent_this_slot != '1) begin
              sent_this_slot <= sent_this_slot + 1'b1;
            end
          end
          MODE_RX_START: begin
            if (radio == RADIO_IDLE) begin
              radio <= RADIO_RX;
            end
          end
          MODE_RX_END: begin
            if (radio == RADIO_TX) begin
              verdict <= VERD_TX_BUSY;
            end else begin
              if (err_r) begin
                verdict <= VERD_CORRUPT;
              end else if (!addr_match) begin
                verdict <= VERD_NOT_MINE;
              end else begin
                verdict <= VERD_DELIVER;
              end
              radio   <= RADIO_IDLE;
              attempt <= 1'b1;
            end
          end
          MODE_START: begin
            slot_countdown <= start_delay_ticks;
            timer_running  <= 1'b1;
          end
          MODE_STOP: begin
            timer_running <= 1'b0;
          end
          default: begin
            attempt <= 1'b0;
          end
        endcase
      end
      if (cmd.pop && tx_go) begin
        tx_flag <= 1'b1;
        head    <= head_inc;
        fill    <= fill - 1'b1;
        radio   <= RADIO_TX;
      end
    end
  end

  // Result register: the entry that left the queue is on the read port here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_tx_start    <= tx_flag;
      out_tx_tag      <= tx_flag ? ram_rdata : '0;
      out_rx_verdict  <= verdict;
      out_dropped     <= drop_flag;
      out_dropped_tag <= drop_flag ? drop_tag_q : '0;
      out_slot_mine   <= own_slot;
      out_queue_count <= fill;
      out_radio_state <= radio;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_BITS'(QUEUE_DEPTH))
    else $error("queue fill exceeds the physical depth");

  a_pop_update: assert property (@(posedge clk) disable iff (rst)
    cmd.pop && tx_go |=> fill == $past(fill) - 1'b1 && radio == RADIO_TX)
    else $error("transmit pop did not update the queue and radio");

  a_tx_radio: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_tx_start |-> out_radio_state == RADIO_TX)
    else $error("transmit result without a transmitting radio");

  a_drop_tag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_dropped |-> out_dropped_tag == '0)
    else $error("dropped tag set without a drop");

endmodule

[rtl/tdma_slot_mac_controller_unit.sv]
// Items pass one at a time through the accept, execute, pop and load steps, and the
// result is registered in the load step. The single read port of the tag store
// sets the execute and pop steps apart.
// A waiting result does not block the next accept but holds that item in its load step.
// Reset (rst, synchronous, active high) clears the scheduler state and sets the
// configuration registers to their defaults; nothing is accepted during reset.
module tdma_slot_mac_controller_unit
  import tdma_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input logic             clk,
  input logic             rst,
  tdma_in_if.sink         item_in,
  tdma_out_if.source      result_out,
  tdma_cfg_if.sink        cfg
);

  // Width of the queue occupancy count, which must hold the depth itself.
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  // The controller steps every item through the same idle, execute, pop and fin states;
  // the scheduler state, the tag store and the result register live in the datapath.
  // The tag store is not cleared by reset; the queue reads only entries it has written.
  dp_cmd_t    cmd;
  dp_status_t status;

  tdma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath keeps the tag queue as a ring in a small RAM. Enqueue writes
  // and the read of an evicted entry share the execute cycle; the RAM returns
  // old data on a same-address read, so an eviction of the entry that is being
  // overwritten still reports the evicted tag. The transmit decision is taken
  // in the pop cycle, after the event has updated the slot, radio and queue.
  tdma_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS),
    .ADDR_BITS   (ADDR_BITS),
    .CNT_BITS    (CNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_mode         (item_in.mode),
    .in_tag          (item_in.packet_tag),
    .in_hi           (item_in.high_priority),
    .in_dest         (item_in.dest_addr),
    .in_err          (item_in.rx_error),
    .cfg_valid       (cfg.valid),
    .cfg_ready       (cfg.ready),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .out_tx_start    (result_out.tx_start),
    .out_tx_tag      (result_out.tx_tag),
    .out_rx_verdict  (result_out.rx_verdict),
    .out_dropped     (result_out.dropped),
    .out_dropped_tag (result_out.dropped_tag),
    .out_slot_mine   (result_out.slot_mine),
    .out_queue_count (result_out.queue_count),
    .out_radio_state (result_out.radio_state)
  );

endmodule

[bench/testbench.sv]
module testbench;
  import tdma_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The run is stopped here if the block hangs. A correct run ends well before
  // this limit, even with every item and result fully stalled.
  localparam int CYCLE_LIMIT = 200000;
  localparam int QDEPTH      = QUEUE_DEPTH_DEF;
  localparam logic [TICK_BITS-1:0] TICKS_MAX = '1;

  // One event as it enters the block.
  typedef struct packed {
    mode_t       mode;
    logic [15:0] tag;
    logic        hi;
    logic [7:0]  dest;
    logic        err;
  } mac_event_t;

  // The status item that the block returns for every event.
  typedef struct packed {
    logic        tx_start;
    logic [15:0] tx_tag;
    verdict_t    verdict;
    logic        dropped;
    logic [15:0] dropped_tag;
    logic        slot_mine;
    logic [4:0]  queue_count;
    radio_t      radio_state;
  } mac_status_t;

  // Tracks the slot timer, the packet queue and the radio of the block, works
  // out the status item that each accepted event must produce, and checks the
  // returned status items against them in order.
  class slot_mac_tracker;
    logic [23:0] frame_len, slot_len, guard_len, start_delay;
    logic [4:0]  q_limit;
    logic [7:0]  per_slot_max;
    logic [1:0]  policy;
    logic [7:0]  own_addr;

    bit          in_slot, running;
    int unsigned countdown, sent;
    radio_t      radio;
    logic [15:0] tags [QDEPTH];
    int unsigned head, fill;

    mac_status_t st;
    mac_status_t awaited[$];
    int          errors;

    function new();
      frame_len    = FRAME_RESET;
      slot_len     = '0;
      guard_len    = '0;
      start_delay  = '0;
      q_limit      = LIMIT_RESET;
      per_slot_max = PER_SLOT_RESET;
      policy       = POLICY_DROP_NEW;
      own_addr     = '0;
      in_slot      = 0;
      running      = 0;
      countdown    = 0;
      sent         = 0;
      radio        = RADIO_IDLE;
      head         = 0;
      fill         = 0;
      errors       = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void write_reg(logic [2:0] idx, logic [23:0] value);
      case (idx)
        CFG_FRAME:        frame_len    = value;
        CFG_SLOT:         slot_len     = value;
        CFG_GUARD:        guard_len    = value;
        CFG_START_DELAY:  start_delay  = value;
        CFG_QUEUE_LIMIT:  q_limit      = value[4:0];
        CFG_MAX_PER_SLOT: per_slot_max = value[7:0];
        CFG_DROP_POLICY:  policy       = value[1:0];
        CFG_MY_ADDR:      own_addr     = value[7:0];
        default: ;
      endcase
    endfunction

    function void put_back(logic [15:0] tag);
      tags[(head + fill) % QDEPTH] = tag;
      fill++;
    endfunction

    function void put_front(logic [15:0] tag);
      head = (head + QDEPTH - 1) % QDEPTH;
      tags[head] = tag;
      fill++;
    endfunction

    function void note_drop(logic [15:0] tag);
      st.dropped     = 1'b1;
      st.dropped_tag = tag;
    endfunction

    // A packet leaves the front of the queue when the slot is ours, the
    // radio is free and the per-slot budget is not used up.
    function void try_send();
      if (sent < per_slot_max && in_slot && radio == RADIO_IDLE && fill > 0) begin
        st.tx_start = 1'b1;
        st.tx_tag   = tags[head];
        head        = (head + 1) % QDEPTH;
        fill--;
        radio = RADIO_TX;
      end
    endfunction

    function void toggle_slot();
      int unsigned off;
      sent = 0;
      if (in_slot) begin
        off       = frame_len + guard_len;
        off       = (off > slot_len) ? off - slot_len : 0;
        in_slot   = 0;
        countdown = (off > TICKS_MAX) ? TICKS_MAX : off;
      end else begin
        in_slot   = 1;
        countdown = (slot_len > guard_len) ? slot_len - guard_len : 0;
        try_send();
      end
    endfunction

    function void enqueue(logic [15:0] tag, logic hi);
      int unsigned lim;
      lim = (q_limit > QDEPTH) ? QDEPTH : q_limit;
      if (fill < lim) begin
        if (policy == POLICY_PRIORITY && hi) put_front(tag);
        else put_back(tag);
      end else if (policy == POLICY_DROP_OLD && fill > 0) begin
        note_drop(tags[head]);
        head = (head + 1) % QDEPTH;
        fill--;
        put_back(tag);
      end else if (policy == POLICY_PRIORITY && hi && fill > 0) begin
        note_drop(tags[(head + fill - 1) % QDEPTH]);
        fill--;
        put_front(tag);
      end else begin
        note_drop(tag);
      end
      try_send();
    endfunction

    function void apply_event(mac_event_t ev);
      st         = '0;
      st.verdict = VERD_NONE;
      case (ev.mode)
        MODE_TICK: begin
          if (running) begin
            if (countdown <= 1) toggle_slot();
            else countdown--;
          end
        end
        MODE_ENQ: enqueue(ev.tag, ev.hi);
        MODE_TX_END: begin
          radio = RADIO_IDLE;
          if (sent < 255) sent++;
          try_send();
        end
        MODE_RX_START: begin
          if (radio == RADIO_IDLE) radio = RADIO_RX;
        end
        MODE_RX_END: begin
          if (radio == RADIO_TX) begin
            st.verdict = VERD_TX_BUSY;
          end else begin
            if (ev.err) st.verdict = VERD_CORRUPT;
            else if (ev.dest != own_addr && ev.dest != 8'hFF) st.verdict = VERD_NOT_MINE;
            else st.verdict = VERD_DELIVER;
            radio = RADIO_IDLE;
            if (in_slot) try_send();
          end
        end
        MODE_START: begin
          countdown = start_delay;
          running   = 1;
        end
        MODE_STOP: running = 0;
        default: ;
      endcase
      st.slot_mine   = in_slot;
      st.queue_count = 5'(fill);
      st.radio_state = radio;
      awaited.insert(awaited.size(), st);
    endfunction

    task check_status(mac_status_t got);
      mac_status_t exp;
      if (awaited.size() == 0) begin
        report("status item arrived with no event waiting");
        return;
      end
      exp = awaited[0];
      awaited.delete(0);
      if (got.tx_start !== exp.tx_start)
        report($sformatf("tx_start %0d, want %0d", got.tx_start, exp.tx_start));
      if (got.tx_tag !== exp.tx_tag)
        report($sformatf("tx_tag %h, want %h", got.tx_tag, exp.tx_tag));
      if (got.verdict !== exp.verdict)
        report($sformatf("rx_verdict %0d, want %0d", got.verdict, exp.verdict));
      if (got.dropped !== exp.dropped)
        report($sformatf("dropped %0d, want %0d", got.dropped, exp.dropped));
      if (got.dropped_tag !== exp.dropped_tag)
        report($sformatf("dropped_tag %h, want %h", got.dropped_tag, exp.dropped_tag));
      if (got.slot_mine !== exp.slot_mine)
        report($sformatf("slot_mine %0d, want %0d", got.slot_mine, exp.slot_mine));
      if (got.queue_count !== exp.queue_count)
        report($sformatf("queue_count %0d, want %0d", got.queue_count, exp.queue_count));
      if (got.radio_state !== exp.radio_state)
        report($sformatf("radio_state %0d, want %0d", got.radio_state, exp.radio_state));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  tdma_in_if  item_in ();
  tdma_out_if result_out ();
  tdma_cfg_if cfg ();

  tdma_slot_mac_controller_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out),
    .cfg        (cfg)
  );

  slot_mac_tracker sb = new();

  // When steady is set, neither side idles, so the block runs back to back.
  // It is drawn again every few dozen events.
  bit steady = 1'b0;
  int events_sent = 0;
  int cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hang: the run ends with the fail message at the limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sends one event. Valid stays high after the accept so that a following
  // event with no gap goes out on the very next cycle. All handshake signals
  // are sampled at the rising edge before the block's own updates land.
  task drive_item(mac_event_t ev);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      item_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_in.valid         <= 1'b1;
    item_in.mode          <= ev.mode;
    item_in.packet_tag    <= ev.tag;
    item_in.high_priority <= ev.hi;
    item_in.dest_addr     <= ev.dest;
    item_in.rx_error      <= ev.err;
    @(posedge clk);
    while (item_in.ready !== 1'b1) @(posedge clk);
    sb.apply_event(ev);
    events_sent++;
    if (events_sent % 40 == 0) steady = ($urandom_range(0, 3) == 0);
  endtask

  task send_event(mode_t m, logic [15:0] tag, logic hi, logic [7:0] dest, logic err);
    mac_event_t ev;
    ev.mode = m;
    ev.tag  = tag;
    ev.hi   = hi;
    ev.dest = dest;
    ev.err  = err;
    drive_item(ev);
  endtask

  // Lowers valid, waits until every expected status item is back, and then
  // lets the block settle before registers change.
  task finish_items();
    item_in.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_register(logic [2:0] idx, logic [23:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (cfg.ready !== 1'b1) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task set_config(logic [23:0] frame, logic [23:0] slot, logic [23:0] guard,
                  logic [23:0] delay, logic [4:0] limit, logic [7:0] per_slot,
                  logic [1:0] policy, logic [7:0] addr);
    write_register(CFG_FRAME, frame);
    write_register(CFG_SLOT, slot);
    write_register(CFG_GUARD, guard);
    write_register(CFG_START_DELAY, delay);
    write_register(CFG_QUEUE_LIMIT, {19'd0, limit});
    write_register(CFG_MAX_PER_SLOT, {16'd0, per_slot});
    write_register(CFG_DROP_POLICY, {22'd0, policy});
    write_register(CFG_MY_ADDR, {16'd0, addr});
    cfg.valid <= 1'b0;
  endtask

  // Random events lean toward ticks and enqueues so that slots turn over and
  // the queue fills and drains. Receive addresses favor our own address and
  // broadcast, so that every verdict shows up often.
  function mac_event_t random_event();
    mac_event_t ev;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 34) ev.mode = MODE_TICK;
    else if (pick < 60) ev.mode = MODE_ENQ;
    else if (pick < 72) ev.mode = MODE_TX_END;
    else if (pick < 80) ev.mode = MODE_RX_START;
    else if (pick < 90) ev.mode = MODE_RX_END;
    else if (pick < 94) ev.mode = MODE_START;
    else if (pick < 97) ev.mode = MODE_STOP;
    else ev.mode = MODE_NOP;
    ev.tag = 16'($urandom_range(0, 65535));
    ev.hi  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: ev.dest = sb.own_addr;
      1: ev.dest = 8'hFF;
      default: ev.dest = 8'($urandom_range(0, 255));
    endcase
    ev.err = ($urandom_range(0, 3) == 0);
    return ev;
  endfunction

  // Each random phase opens with a start so that the slot timer runs.
  task run_random(int count);
    send_event(MODE_START, 16'h0, 1'b0, 8'h0, 1'b0);
    repeat (count - 1) drive_item(random_event());
  endtask

  // Result side: the receiver stalls for a random number of cycles before
  // each status item, then takes it as soon as it is offered.
  initial begin
    mac_status_t got;
    int stall;
    result_out.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        result_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_out.ready <= 1'b1;
      @(posedge clk);
      while (result_out.valid !== 1'b1) @(posedge clk);
      got.tx_start    = result_out.tx_start;
      got.tx_tag      = result_out.tx_tag;
      got.verdict     = verdict_t'(result_out.rx_verdict);
      got.dropped     = result_out.dropped;
      got.dropped_tag = result_out.dropped_tag;
      got.slot_mine   = result_out.slot_mine;
      got.queue_count = result_out.queue_count;
      got.radio_state = radio_t'(result_out.radio_state);
      sb.check_status(got);
    end
  end

  initial begin
    item_in.valid         <= 1'b0;
    item_in.mode          <= MODE_TICK;
    item_in.packet_tag    <= '0;
    item_in.high_priority <= 1'b0;
    item_in.dest_addr     <= '0;
    item_in.rx_error      <= 1'b0;
    cfg.valid             <= 1'b0;
    cfg.index             <= CFG_FRAME;
    cfg.data              <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: a short frame, a queue of two and priority insertion.
    set_config(24'd4, 24'd2, 24'd0, 24'd1, 5'd2, 8'd1, POLICY_PRIORITY, 8'h5A);
    // Deliver, corrupt and not-mine verdicts, including a receive end with no start before it.
    send_event(MODE_RX_END, 16'h0, 1'b0, 8'h5A, 1'b0);
    send_event(MODE_RX_START, 16'h0, 1'b0, 8'h0, 1'b0);
    send_event(MODE_RX_END, 16'h0, 1'b0, 8'hFF, 1'b0);
    send_event(MODE_RX_START, 16'h0, 1'b0, 8'h0, 1'b0);
    send_event(MODE_RX_END, 16'h0, 1'b0, 8'h5A, 1'b1);
    send_event(MODE_RX_END, 16'h0, 1'b0, 8'h00, 1'b0);
    // Fill the queue, put a priority tag in front, then overflow it twice:
    // once evicting the back for priority, once dropping the newcomer.
    send_event(MODE_ENQ, 16'hFFFF, 1'b0, 8'h0, 1'b0);
    send_event(MODE_ENQ, 16'h0000, 1'b1, 8'h0, 1'b0);
    send_event(MODE_ENQ, 16'h1234, 1'b1, 8'h0, 1'b0);
    send_event(MODE_ENQ, 16'h8001, 1'b0, 8'h0, 1'b0);
    // A tick while the timer is stopped changes nothing.
    send_event(MODE_TICK, 16'h0, 1'b0, 8'h0, 1'b0);
    // Start, enter our slot and transmit; receive attempts meet a busy radio.
    send_event(MODE_START, 16'h0, 1'b0, 8'h0, 1'b0);
    send_event(MODE_TICK, 16'h0, 1'b0, 8'h0, 1'b0);
    send_event(MODE_RX_START, 16'h0, 1'b0, 8'h0, 1'b0);
    send_event(MODE_RX_END, 16'h0, 1'b0, 8'h5A, 1'b0);
    send_event(MODE_ENQ, 16'hAAAA, 1'b0, 8'h0, 1'b0);
    // The per-slot budget of one holds back the next packet.
    send_event(MODE_TX_END, 16'h0, 1'b0, 8'h0, 1'b0);
    send_event(MODE_TICK, 16'h0, 1'b0, 8'h0, 1'b0);
    send_event(MODE_TICK, 16'h0, 1'b0, 8'h0, 1'b0);
    // Stop keeps the slot state; a transmit end with an idle radio still counts.
    send_event(MODE_STOP, 16'h0, 1'b0, 8'h0, 1'b0);
    send_event(MODE_TICK, 16'h0, 1'b0, 8'h0, 1'b0);
    send_event(MODE_TX_END, 16'h0, 1'b0, 8'h0, 1'b0);
    send_event(MODE_NOP, 16'h5555, 1'b1, 8'hAA, 1'b1);
    run_random(120);
    finish_items();

    // Zero-length frame and slots: the slot flips on every tick.
    set_config(24'd0, 24'd0, 24'd0, 24'd0, 5'd16, 8'd255, POLICY_DROP_OLD, 8'd0);
    run_random(150);
    finish_items();

    // Largest timings, no queue room and no transmit budget.
    set_config(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, 5'd0, 8'd0,
               POLICY_DROP_NEW, 8'd254);
    run_random(60);
    finish_items();

    // The off period overflows the tick range and saturates.
    set_config(TICKS_MAX, 24'd0, TICKS_MAX, 24'd0, 5'd16, 8'd1, POLICY_PRIORITY, 8'h81);
    run_random(50);
    finish_items();

    set_config(24'd8, 24'd5, 24'd2, 24'd3, 5'd5, 8'd2, POLICY_PRIORITY,
               8'($urandom_range(0, 254)));
    run_random(150);
    finish_items();

    // The guard exceeds the slot, so the own slot has zero length.
    set_config(24'd3, 24'd7, 24'd9, 24'd0, 5'd1, 8'd3, POLICY_DROP_OLD,
               8'($urandom_range(0, 254)));
    run_random(120);
    finish_items();

    repeat (4) begin
      set_config(24'($urandom_range(0, 12)), 24'($urandom_range(0, 8)),
                 24'($urandom_range(0, 3)), 24'($urandom_range(0, 5)),
                 5'($urandom_range(0, 16)),
                 ($urandom_range(0, 4) == 0) ? 8'd255 : 8'($urandom_range(0, 4)),
                 2'($urandom_range(0, 2)), 8'($urandom_range(0, 254)));
      run_random(60);
      finish_items();
    end

    repeat (10) @(posedge clk);
    if (sb.awaited.size() != 0) sb.report("status items still outstanding at the end");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tdma_pkg.sv
rtl/tdma_if.sv
rtl/tdma_ram.sv
rtl/tdma_ctrl.sv
rtl/tdma_dp.sv
rtl/tdma_slot_mac_controller_unit.sv
bench/testbench.sv
